>>> rtl/md4bc_pkg.sv
package md4bc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [31:0] K_ROUND0 = 32'h00000000;
    localparam logic [31:0] K_ROUND1 = 32'h5a827999;
    localparam logic [31:0] K_ROUND2 = 32'h6ed9eba1;

    localparam logic [5:0] LAST_STEP = 6'd47;
    localparam logic [3:0] LAST_WORD = 4'd15;

    // One classified beat as it travels from the front end to the core.
    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  idx;
        logic        restart;
        logic        last;
    } md4bc_item_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_FINAL
    } md4bc_state_t;

    // Message word used by each of the 48 steps.
    function automatic logic [3:0] md4bc_word_index(input logic [5:0] step);
        logic [3:0] s;
        logic [3:0] r;
        s = step[3:0];
        case (step[5:4])
            2'd0:    r = s;
            2'd1:    r = {s[1:0], s[3:2]};
            2'd2:    r = {s[0], s[1], s[2], s[3]};
            default: r = s;
        endcase
        return r;
    endfunction

    // Left rotate amount by round and by position within a group of four.
    function automatic logic [4:0] md4bc_rot_amount(input logic [1:0] rnd,
                                                    input logic [1:0] pos);
        logic [4:0] r;
        case (rnd)
            2'd0: begin
                case (pos)
                    2'd0:    r = 5'd3;
                    2'd1:    r = 5'd7;
                    2'd2:    r = 5'd11;
                    default: r = 5'd19;
                endcase
            end
            2'd1: begin
                case (pos)
                    2'd0:    r = 5'd3;
                    2'd1:    r = 5'd5;
                    2'd2:    r = 5'd9;
                    default: r = 5'd13;
                endcase
            end
            default: begin
                case (pos)
                    2'd0:    r = 5'd3;
                    2'd1:    r = 5'd9;
                    2'd2:    r = 5'd11;
                    default: r = 5'd15;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] md4bc_rotl(input logic [31:0] v,
                                               input logic [4:0] s);
        logic [63:0] t;
        t = {32'd0, v} << s;
        return t[31:0] | t[63:32];
    endfunction

endpackage

>>> rtl/md4_block_compress_top.sv
// MD4 block compression unit.
// Input stream (s_*): one beat per 32-bit message word, sixteen beats per
// 512-bit block, with the four bytes of each word assembled little-endian.
// s_tuser set on a beat marks the first word of a new message: the chaining
// value is reloaded with the MD4 initial words and any partial block is
// dropped. Without it, hashing continues from the previous block's result.
// Output stream (m_*): one beat per finished block carrying the updated
// chaining value A, B, C, D in m_tdata, A in the lowest 32 bits.
// A front end tags each word with its slot in the block and pushes it into a
// four-entry queue. The compression core drains the queue at one word per
// cycle while the queue holds words, then runs the 48 steps one per cycle on
// a single round datapath, and then makes the final add into the chaining
// value. Words keep arriving into the queue during the rounds until it fills.
// When the receiver stalls, the result waits in the output register; the
// core holds in its final step until that register is free, and s_tready
// falls once the queue is full.
// Reset clears the word count, the queue and the output valid, and loads the
// chaining value with the MD4 initial words.
module md4_block_compress_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] message_word
    input  logic         s_tuser,   // [0] restart
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [31:0] digest_a, [63:32] digest_b,
                                    // [95:64] digest_c, [127:96] digest_d
);

    md4bc_pkg::md4bc_item_t push_item;
    md4bc_pkg::md4bc_item_t pop_item;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    md4bc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    md4bc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (pop_item)
    );

    md4bc_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> rtl/md4bc_front.sv
module md4bc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic                 s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output md4bc_pkg::md4bc_item_t q_item
);

    // Position of the next word within its block.
    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic [3:0] idx;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // A restart makes the current word the first of a fresh block.
    assign idx        = s_tuser ? 4'd0 : count_reg;
    assign count_next = idx + 4'd1;

    always_comb begin
        q_item.word    = s_tdata;
        q_item.idx     = idx;
        q_item.restart = s_tuser;
        q_item.last    = (idx == md4bc_pkg::LAST_WORD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 4'd0;
        end else if (q_push) begin
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/md4bc_queue.sv
module md4bc_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  md4bc_pkg::md4bc_item_t push_item,
    output logic                   full,
    input  logic                   pop,
    output logic                   empty,
    output md4bc_pkg::md4bc_item_t pop_item
);

    md4bc_pkg::md4bc_item_t slot_reg [md4bc_pkg::QUEUE_DEPTH];

    logic [md4bc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [md4bc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [md4bc_pkg::QCNT_W-1:0] count_reg;
    logic [md4bc_pkg::QCNT_W-1:0] count_next;
    logic                         do_push;
    logic                         do_pop;

    assign full     = (count_reg == md4bc_pkg::QCNT_W'(md4bc_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/md4bc_core.sv
module md4bc_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_empty,
    input  md4bc_pkg::md4bc_item_t q_item,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [127:0]           m_tdata
);

    md4bc_pkg::md4bc_state_t state_reg;
    md4bc_pkg::md4bc_state_t state_next;

    logic [31:0] store_reg [16];
    logic [31:0] cv_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  step_reg;
    logic        out_valid_reg;
    logic [127:0] out_data_reg;

    logic        out_free;
    logic        finish;
    logic [1:0]  rnd;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] sum;
    logic [31:0] new_a;
    logic [31:0] fin_a, fin_b, fin_c, fin_d;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            md4bc_pkg::ST_LOAD: begin
                q_pop = !q_empty;
                if (!q_empty && q_item.last) begin
                    state_next = md4bc_pkg::ST_ROUND;
                end
            end
            md4bc_pkg::ST_ROUND: begin
                if (step_reg == md4bc_pkg::LAST_STEP) begin
                    state_next = md4bc_pkg::ST_FINAL;
                end
            end
            md4bc_pkg::ST_FINAL: begin
                if (out_free) begin
                    finish     = 1'b1;
                    state_next = md4bc_pkg::ST_LOAD;
                end
            end
            default: state_next = md4bc_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= md4bc_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // One MD4 step: the working words rotate so the word to be updated is always a.
    assign rnd = step_reg[5:4];

    always_comb begin
        case (rnd)
            2'd0: begin
                f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
                k_val = md4bc_pkg::K_ROUND0;
            end
            2'd1: begin
                f_val = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
                k_val = md4bc_pkg::K_ROUND1;
            end
            default: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = md4bc_pkg::K_ROUND2;
            end
        endcase
    end

    assign sum   = a_reg + f_val + store_reg[md4bc_pkg::md4bc_word_index(step_reg)] + k_val;
    assign new_a = md4bc_pkg::md4bc_rotl(sum,
                       md4bc_pkg::md4bc_rot_amount(rnd, step_reg[1:0]));

    assign fin_a = cv_reg[0] + a_reg;
    assign fin_b = cv_reg[1] + b_reg;
    assign fin_c = cv_reg[2] + c_reg;
    assign fin_d = cv_reg[3] + d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0]     <= md4bc_pkg::IV_A;
            cv_reg[1]     <= md4bc_pkg::IV_B;
            cv_reg[2]     <= md4bc_pkg::IV_C;
            cv_reg[3]     <= md4bc_pkg::IV_D;
            step_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop && q_item.restart) begin
                cv_reg[0] <= md4bc_pkg::IV_A;
                cv_reg[1] <= md4bc_pkg::IV_B;
                cv_reg[2] <= md4bc_pkg::IV_C;
                cv_reg[3] <= md4bc_pkg::IV_D;
            end else if (finish) begin
                cv_reg[0] <= fin_a;
                cv_reg[1] <= fin_b;
                cv_reg[2] <= fin_c;
                cv_reg[3] <= fin_d;
            end
            if (state_reg == md4bc_pkg::ST_ROUND) begin
                step_reg <= step_reg + 6'd1;
            end else begin
                step_reg <= 6'd0;
            end
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            store_reg[q_item.idx] <= q_item.word;
        end
        if (q_pop && q_item.last) begin
            a_reg <= cv_reg[0];
            b_reg <= cv_reg[1];
            c_reg <= cv_reg[2];
            d_reg <= cv_reg[3];
        end else if (state_reg == md4bc_pkg::ST_ROUND) begin
            a_reg <= d_reg;
            b_reg <= new_a;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
        if (finish) begin
            out_data_reg <= {fin_d, fin_c, fin_b, fin_a};
        end
    end

    // The step counter never runs past the last step of a block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == md4bc_pkg::ST_ROUND) |-> (step_reg <= md4bc_pkg::LAST_STEP))
        else $error("step counter overran");

    // Taking the sixteenth word of a block starts the rounds at step zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.last) |=> (state_reg == md4bc_pkg::ST_ROUND && step_reg == 6'd0))
        else $error("compression did not start");

    // Finishing a block always leaves a result waiting at the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> m_tvalid)
        else $error("finished block produced no result");

    // No word is taken from the queue while a block is being compressed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == md4bc_pkg::ST_LOAD))
        else $error("word taken during compression");

endmodule

>>> bench/tb_md4_block_compress_top.sv
module tb_md4_block_compress_top;

    // Cycles with no beat on either side before the run is declared hung. Each block runs
    // through the load, round and final states of the core, and stalls on the sender and
    // the receiver lengthen it. The drain at the end waits on past the last digest.
    localparam int HANG_LIMIT  = 1000;
    localparam int DRAIN_WAIT  = 100;
    localparam int WORD_TARGET = 1950;

    // Software model of the compression unit. It keeps its own chaining value
    // and block buffer, and queues one digest each time its block of sixteen words fills.
    class digest_scoreboard;
        logic [31:0]  block_words [16];
        logic [3:0]   fill;
        logic [31:0]  chain [4];
        logic [127:0] digest_q [$];
        int           errors;

        function new();
            fill   = '0;
            chain  = '{md4bc_pkg::IV_A, md4bc_pkg::IV_B, md4bc_pkg::IV_C,
                       md4bc_pkg::IV_D};
            errors = 0;
        endfunction

        function int pending();
            return digest_q.size();
        endfunction

        // Called for every accepted input beat.
        function void note_word(input logic [31:0] word, input logic restart);
            logic [31:0] w [4];
            logic [31:0] bw, cw, dw, f, k, sum;
            logic [3:0]  j, idx;
            int          i, rnd, pos, ia, s;
            if (restart) begin
                chain = '{md4bc_pkg::IV_A, md4bc_pkg::IV_B, md4bc_pkg::IV_C,
                          md4bc_pkg::IV_D};
                fill  = '0;
            end
            block_words[fill] = word;
            fill = fill + 4'd1;
            if (fill != 4'd0)
                return;
            w = chain;
            for (i = 0; i < 48; i++) begin
                rnd = i / 16;
                pos = i % 4;
                j   = i[3:0];
                // The word being updated walks a, d, c, b within each group of four.
                ia  = (4 - pos) % 4;
                bw  = w[(ia + 1) % 4];
                cw  = w[(ia + 2) % 4];
                dw  = w[(ia + 3) % 4];
                case (rnd)
                    0: begin
                        f   = dw ^ (bw & (cw ^ dw));
                        k   = md4bc_pkg::K_ROUND0;
                        idx = j;
                    end
                    1: begin
                        f   = (bw & cw) | (dw & (bw | cw));
                        k   = md4bc_pkg::K_ROUND1;
                        idx = {j[1:0], j[3:2]};
                    end
                    default: begin
                        f   = bw ^ cw ^ dw;
                        k   = md4bc_pkg::K_ROUND2;
                        idx = {j[0], j[1], j[2], j[3]};
                    end
                endcase
                case (rnd * 4 + pos)
                    0:       s = 3;
                    1:       s = 7;
                    2:       s = 11;
                    3:       s = 19;
                    4:       s = 3;
                    5:       s = 5;
                    6:       s = 9;
                    7:       s = 13;
                    8:       s = 3;
                    9:       s = 9;
                    10:      s = 11;
                    default: s = 15;
                endcase
                sum   = w[ia] + f + block_words[idx] + k;
                w[ia] = (sum << s) | (sum >> (32 - s));
            end
            for (i = 0; i < 4; i++)
                chain[i] = chain[i] + w[i];
            digest_q.push_back({chain[3], chain[2], chain[1], chain[0]});
        endfunction

        // Called for every accepted output beat.
        function void check_digest(input logic [127:0] data);
            logic [127:0] want;
            string        names [4];
            int           i;
            names = '{"digest_a", "digest_b", "digest_c", "digest_d"};
            if (digest_q.size() == 0) begin
                errors++;
                $error("digest beat with nothing expected: %h", data);
                return;
            end
            want = digest_q.pop_front();
            for (i = 0; i < 4; i++) begin
                if (data[32*i +: 32] !== want[32*i +: 32]) begin
                    errors++;
                    $error("%s: expected %h, got %h", names[i], want[32*i +: 32],
                           data[32*i +: 32]);
                end
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;   // [31:0] message_word
    logic         s_tuser;   // [0] restart
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // [31:0] digest_a, [63:32] digest_b,
                             // [95:64] digest_c, [127:96] digest_d

    digest_scoreboard sb = new();

    int words_sent;
    int stall_cycles;
    bit send_burst;
    bit recv_burst;

    md4_block_compress_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Drive one word beat. The call starts and ends at a rising edge. The valid
    // signal is lowered only for a real gap, so it never toggles twice in a step.
    task automatic send_word(input logic [31:0] word, input logic restart);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(word, restart);
        words_sent++;
    endtask

    // Word values are biased toward the corners: zero, all ones, and a single bit
    // set or cleared. Plain random words still make up most of them.
    function automatic logic [31:0] pick_word();
        logic [31:0] one_hot;
        one_hot = 32'd1 << $urandom_range(0, 31);
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return $urandom;
        endcase
    endfunction

    // Wait until the model has no digest outstanding. The check is made only
    // after a rising edge, also when nothing is outstanding.
    task automatic wait_drained();
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Receiver. It stalls a random number of cycles before each beat, or none
    // at all during burst stretches.
    initial begin
        int gap;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            gap = recv_burst ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_digest(m_tdata);
            if ($urandom_range(0, 15) == 0)
                recv_burst = !recv_burst;
        end
    end

    // The watchdog is reset by any beat on either side.
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_cycles <= 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= HANG_LIMIT) begin
                $error("no beat accepted for %0d cycles", HANG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int  i, len;
        bit  force_restart, paused;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= 1'b0;
        words_sent    = 0;
        send_burst    = 0;
        recv_burst    = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The first block is restarted and alternates zero and all
        // ones. The next block carries on from that digest without a restart.
        // After five words of that block a restart drops them mid-block.
        for (i = 0; i < 16; i++)
            send_word(i[0] ? 32'hffff_ffff : 32'h0000_0000, i == 0);
        send_word(32'h0000_0080, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h7fff_ffff, 1'b0);
        send_word(32'hffff_fffe, 1'b0);
        send_word(32'hffff_ffff, 1'b1);

        // Random part. Most runs are whole 16-word blocks that are either restarted
        // or chained onto the previous digest. About one run in eight is cut short,
        // and the run after it restarts in the middle of the block.
        force_restart = 1;
        paused        = 0;
        while (words_sent < WORD_TARGET) begin
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(1, 15);
            else
                len = 16;
            for (i = 0; i < len; i++)
                send_word(pick_word(),
                          (i == 0) && (force_restart || $urandom_range(0, 2) == 0));
            force_restart = (len != 16);
            if ($urandom_range(0, 7) == 0)
                send_burst = !send_burst;
            // Once, halfway through, hold the sender until every digest is out.
            if (!paused && words_sent >= WORD_TARGET / 2) begin
                paused    = 1;
                s_tvalid <= 1'b0;
                wait_drained();
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d digests never arrived", sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> md4_block_compress_top.f
rtl/md4bc_pkg.sv
rtl/md4bc_front.sv
rtl/md4bc_queue.sv
rtl/md4bc_core.sv
rtl/md4_block_compress_top.sv
bench/tb_md4_block_compress_top.sv
